@@ design/tera_pkg.sv @@
// Shared types and constants for the two-ended region allocator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package tera_pkg;

   localparam logic [31:0] BASE_RESET = 32'h2000_0000;
   localparam logic [17:0] MAX_ALIGN  = 18'd131072;

   typedef enum logic [1:0] {
      OP_ALLOC_TEMP = 2'd0,
      OP_ALLOC_LONG = 2'd1,
      OP_FREE_TEMP  = 2'd2,
      OP_FREE_LONG  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_ALIGN_POW2  = 4'd1,
      ST_ALIGN_BIG   = 4'd2,
      ST_TABLE_FULL  = 4'd3,
      ST_ZERO_SIZE   = 4'd4,
      ST_NO_SPACE    = 4'd5,
      ST_NULL_FREE   = 4'd6,
      ST_OUTSIDE     = 4'd7,
      ST_NOT_ALLOC   = 4'd8,
      ST_OWNER       = 4'd9,
      ST_WRONG_KIND  = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SEARCH,
      S_RESCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic cfg_wr;
      logic check;
      logic srch_step;
      logic commit;
      logic miss;
      logic rescan_step;
      logic rescan_end;
   } cmd_type;

   typedef struct packed {
      logic chk_fail;
      logic hit;
      logic last;
      logic rescan_need;
   } stat_type;

endpackage

`default_nettype wire

@@ design/tera_ctrl.sv @@
// Controller state machine of the region allocator.
// Depends on tera_pkg; drives the datapath through cmd_type, reads stat_type.
`default_nettype none

module tera_ctrl
   import tera_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire logic     rsp_stall,
   output logic          rsp_valid,
   input  wire logic     csr_valid,
   output logic          csr_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.chk_fail ? S_RESP : S_SEARCH;
         end
         S_SEARCH: begin
            if (stat.hit) begin
               state_in = stat.rescan_need ? S_RESCAN : S_RESP;
            end else if (stat.last) begin
               state_in = S_RESP;
            end
         end
         S_RESCAN: begin
            if (stat.last) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // a waiting request goes first; the csr write waits for a free idle cycle
            req_stall  = 1'b0;
            csr_ready  = !req_valid;
            cmd.load   = req_valid;
            cmd.cfg_wr = csr_valid && !req_valid;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
         end
         S_SEARCH: begin
            cmd.commit    = stat.hit;
            cmd.miss      = !stat.hit && stat.last;
            cmd.srch_step = !stat.hit && !stat.last;
         end
         S_RESCAN: begin
            cmd.rescan_step = 1'b1;
            cmd.rescan_end  = stat.last;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/tera_dpath.sv @@
// Datapath of the region allocator: marks, counts, slot table, checks, scans.
// Depends on tera_pkg; controlled by tera_ctrl through cmd_type / stat_type.
`default_nettype none

module tera_dpath
   import tera_pkg::*;
#(
   parameter int TOTAL_BYTES      = 139264,
   parameter int LONG_LIVED_BYTES = 8192,
   parameter int MAX_ALLOCS       = 32,
   parameter int IDX_W            = 5
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  req_operation,
   input  wire logic [17:0] req_byte_count,
   input  wire logic [17:0] req_alignment,
   input  wire logic [7:0]  req_owner_tag,
   input  wire logic [31:0] req_free_address,
   input  wire logic [31:0] csr_base_address,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   output logic [3:0]       rsp_status,
   output logic [31:0]      rsp_granted_address,
   output logic [17:0]      rsp_free_space
);

   localparam logic [31:0] TOTAL32 = 32'(TOTAL_BYTES);
   localparam logic [31:0] LONG32  = 32'(LONG_LIVED_BYTES);
   localparam logic [31:0] LIMIT   = 32'hFFFF_FFFF - TOTAL32;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ALLOCS - 1);
   localparam logic [6:0] MAX7 = 7'(MAX_ALLOCS);

   logic [31:0] base_ff, low_ff, high_ff;
   logic [5:0]  temp_cnt_ff, long_cnt_ff;
   logic [MAX_ALLOCS-1:0] valid_ff;
   logic [31:0] slot_addr_ff  [MAX_ALLOCS];
   logic [17:0] slot_size_ff  [MAX_ALLOCS];
   logic [7:0]  slot_owner_ff [MAX_ALLOCS];
   logic        slot_long_ff  [MAX_ALLOCS];

   op_type      op_ff;
   logic [17:0] count_ff, align_ff;
   logic [7:0]  owner_ff;
   logic [31:0] addr_ff, start_ff, mark_ff, granted_ff;
   status_type  status_ff;
   logic [IDX_W-1:0] idx_ff;

   logic        is_long, is_free;
   logic [31:0] region_end, floor_c, lower, avail, start_c, mask32;
   logic [32:0] up33;
   logic [17:0] align_eff, mask18;
   status_type  chk_code;

   assign is_long    = op_ff[0];
   assign is_free    = op_ff[1];
   assign region_end = base_ff + TOTAL32;
   assign floor_c    = (LONG32 >= TOTAL32) ? base_ff : region_end - LONG32;

   // request checks and start address, evaluated in the check cycle
   always_comb begin
      align_eff = (align_ff == 18'd0) ? 18'd1 : align_ff;
      mask18    = align_eff - 18'd1;
      mask32    = {14'd0, mask18};
      lower     = (is_long && floor_c > low_ff) ? floor_c : low_ff;
      avail     = (high_ff > lower) ? high_ff - lower : 32'd0;
      up33      = ({1'b0, low_ff} + {15'd0, align_eff}) & ~{1'b0, mask32};
      start_c   = low_ff;
      chk_code  = ST_OK;
      if (is_free) begin
         if (addr_ff == 32'd0) begin
            chk_code = ST_NULL_FREE;
         end else if (addr_ff < base_ff || addr_ff >= region_end) begin
            chk_code = ST_OUTSIDE;
         end
      end else if ((align_eff & mask18) != 18'd0) begin
         chk_code = ST_ALIGN_POW2;
      end else if (align_eff > MAX_ALIGN) begin
         chk_code = ST_ALIGN_BIG;
      end else if ({1'b0, temp_cnt_ff} + {1'b0, long_cnt_ff} >= MAX7) begin
         chk_code = ST_TABLE_FULL;
      end else if (count_ff == 18'd0) begin
         chk_code = ST_ZERO_SIZE;
      end else if ({14'd0, count_ff} > avail) begin
         chk_code = ST_NO_SPACE;
      end else begin
         if (!is_long) begin
            if ((low_ff & mask32) != 32'd0) begin
               start_c = up33[31:0];
               if (up33 > {1'b0, high_ff} ||
                   (high_ff - up33[31:0]) < {14'd0, count_ff}) begin
                  chk_code = ST_NO_SPACE;
               end
            end
         end else begin
            start_c = high_ff - {14'd0, count_ff};
            if ((start_c & mask32) != 32'd0) begin
               start_c = start_c & ~mask32;
               if (lower > start_c) chk_code = ST_NO_SPACE;
            end
         end
         if (start_c == 32'd0) chk_code = ST_NO_SPACE;
      end
   end

   // slot under the scan index
   logic        cur_valid, cur_long, free_ok;
   logic [31:0] cur_addr, cur_end, mark_nx;
   logic [5:0]  dec_cnt;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_long  = slot_long_ff[idx_ff];
   assign cur_addr  = slot_addr_ff[idx_ff];
   assign cur_end   = cur_addr + {14'd0, slot_size_ff[idx_ff]};
   assign free_ok   = (slot_owner_ff[idx_ff] == owner_ff) && (cur_long == is_long);
   assign dec_cnt   = is_long ? ((long_cnt_ff != 6'd0) ? long_cnt_ff - 6'd1 : 6'd0)
                              : ((temp_cnt_ff != 6'd0) ? temp_cnt_ff - 6'd1 : 6'd0);

   always_comb begin
      mark_nx = mark_ff;
      if (cur_valid && cur_long == is_long) begin
         if (!is_long && cur_end > mark_ff) mark_nx = cur_end;
         if (is_long && cur_addr < mark_ff) mark_nx = cur_addr;
      end
   end

   assign stat.chk_fail    = (chk_code != ST_OK);
   assign stat.hit         = is_free ? (cur_valid && cur_addr == addr_ff) : !cur_valid;
   assign stat.last        = (idx_ff == IDX_LAST);
   assign stat.rescan_need = is_free && free_ok && (dec_cnt != 6'd0);

   // marks, counts and valid bits
   logic [31:0] base_new;
   assign base_new = (csr_base_address > LIMIT) ? LIMIT : csr_base_address;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_RESET;
         low_ff      <= BASE_RESET;
         high_ff     <= BASE_RESET + TOTAL32;
         temp_cnt_ff <= 6'd0;
         long_cnt_ff <= 6'd0;
         valid_ff    <= '0;
      end else if (cmd.cfg_wr) begin
         base_ff     <= base_new;
         low_ff      <= base_new;
         high_ff     <= base_new + TOTAL32;
         temp_cnt_ff <= 6'd0;
         long_cnt_ff <= 6'd0;
         valid_ff    <= '0;
      end else if (cmd.commit) begin
         if (!is_free) begin
            valid_ff[idx_ff] <= 1'b1;
            if (is_long) begin
               high_ff     <= start_ff;
               long_cnt_ff <= long_cnt_ff + 6'd1;
            end else begin
               low_ff      <= start_ff + {14'd0, count_ff};
               temp_cnt_ff <= temp_cnt_ff + 6'd1;
            end
         end else if (free_ok) begin
            valid_ff[idx_ff] <= 1'b0;
            if (is_long) begin
               long_cnt_ff <= dec_cnt;
               if (dec_cnt == 6'd0) high_ff <= region_end;
            end else begin
               temp_cnt_ff <= dec_cnt;
               if (dec_cnt == 6'd0) low_ff <= base_ff;
            end
         end
      end else if (cmd.rescan_end) begin
         if (is_long) high_ff <= mark_nx;
         else low_ff <= mark_nx;
      end
   end

   // slot payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.commit && !is_free) begin
         slot_addr_ff[idx_ff]  <= start_ff;
         slot_size_ff[idx_ff]  <= count_ff;
         slot_owner_ff[idx_ff] <= owner_ff;
         slot_long_ff[idx_ff]  <= is_long;
      end
   end

   // request, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_operation);
         count_ff   <= req_byte_count;
         align_ff   <= req_alignment;
         owner_ff   <= req_owner_tag;
         addr_ff    <= req_free_address;
         idx_ff     <= '0;
         granted_ff <= 32'd0;
      end
      if (cmd.check) begin
         status_ff <= chk_code;
         start_ff  <= start_c;
      end
      if (cmd.srch_step || cmd.rescan_step) idx_ff <= idx_ff + IDX_W'(1);
      if (cmd.rescan_step) mark_ff <= mark_nx;
      if (cmd.miss) status_ff <= is_free ? ST_NOT_ALLOC : ST_TABLE_FULL;
      if (cmd.commit) begin
         idx_ff  <= '0;
         mark_ff <= is_long ? region_end : base_ff;
         if (!is_free) begin
            status_ff  <= ST_OK;
            granted_ff <= start_ff;
         end else if (slot_owner_ff[idx_ff] != owner_ff) begin
            status_ff <= ST_OWNER;
         end else if (cur_long != is_long) begin
            status_ff <= ST_WRONG_KIND;
         end else begin
            status_ff <= ST_OK;
         end
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_granted_address = granted_ff;
   assign rsp_free_space      = (high_ff > low_ff) ? 18'(high_ff - low_ff) : 18'd0;

endmodule

`default_nettype wire

@@ design/two_ended_region_allocator_core.sv @@
// Two-ended region allocator: temporary blocks grow up from the low mark,
// long-lived blocks grow down from the high mark, tracked in a slot table.
//
// Request channel (req_*): valid/stall; a transaction is taken when req_valid
// is high and req_stall low. One request is worked on at a time.
// Response channel (rsp_*): one response per request, held in registers
// while rsp_stall is high; the block takes no new request until it leaves.
// CSR channel (csr_*): valid/ready write of base_address, taken only while
// idle with no request offered; it saturates the base and re-initializes
// marks, counts and slots.
// Request flow: a failed check goes straight to the response; an allocation
// walks the slot table for a free slot, one slot per cycle; a free walks it
// for the matching address and, when blocks of that kind remain, walks all
// MAX_ALLOCS slots again to rebuild the mark. The block returns to idle
// after each response before it accepts the next request.
// Reset (synchronous): base 0x20000000, empty table, full free space.
`default_nettype none

module two_ended_region_allocator_core
   import tera_pkg::*;
#(
   parameter int TOTAL_BYTES      = 139264,
   parameter int LONG_LIVED_BYTES = 8192,
   parameter int MAX_ALLOCS       = 32
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [17:0] req_byte_count,
   input  wire logic [17:0] req_alignment,
   input  wire logic [7:0]  req_owner_tag,
   input  wire logic [31:0] req_free_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [31:0]      rsp_granted_address,
   output logic [17:0]      rsp_free_space,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_base_address
);

   localparam int IDX_W = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;

   cmd_type  cmd;
   stat_type stat;

   tera_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tera_dpath #(
      .TOTAL_BYTES      (TOTAL_BYTES),
      .LONG_LIVED_BYTES (LONG_LIVED_BYTES),
      .MAX_ALLOCS       (MAX_ALLOCS),
      .IDX_W            (IDX_W)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_operation),
      .req_byte_count      (req_byte_count),
      .req_alignment       (req_alignment),
      .req_owner_tag       (req_owner_tag),
      .req_free_address    (req_free_address),
      .csr_base_address    (csr_base_address),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_space      (rsp_free_space)
   );

   // a pending response always blocks new requests
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // only a successful allocation carries an address
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_granted_address == 32'd0))
      else $error("address granted on failure");

   // csr writes are taken only while idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("csr ready outside idle");

   // an accepted request cannot answer in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response too early");

endmodule

`default_nettype wire

@@ tb/tb_two_ended_region_allocator_core.sv @@
// Self-checking testbench for two_ended_region_allocator_core: random and directed
// allocate/free transactions checked against an in-bench allocator model.
// Depends on tera_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_two_ended_region_allocator_core;
   import tera_pkg::*;

   localparam int TOTAL      = 139264;
   localparam int LONG_BYTES = 8192;
   localparam int NSLOT      = 32;
   localparam int WD_LIMIT   = 20000;

   typedef struct {
      op_type      op;
      logic [17:0] cnt;
      logic [17:0] aln;
      logic [7:0]  own;
      logic [31:0] addr;
   } alloc_req_type;

   typedef struct {
      status_type  st;
      logic [31:0] grant;
      logic [17:0] space;
   } alloc_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_operation = 0;
   logic [17:0] req_byte_count = 0;
   logic [17:0] req_alignment = 0;
   logic [7:0] req_owner_tag = 0;
   logic [31:0] req_free_address = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [3:0] rsp_status;
   logic [31:0] rsp_granted_address;
   logic [17:0] rsp_free_space;
   logic csr_valid = 0;
   logic csr_ready;
   logic [31:0] csr_base_address = 0;

   two_ended_region_allocator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_byte_count(req_byte_count),
      .req_alignment(req_alignment), .req_owner_tag(req_owner_tag),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_granted_address(rsp_granted_address),
      .rsp_free_space(rsp_free_space),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_base_address(csr_base_address)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // allocator model state
   logic [63:0] m_base, m_low, m_high;
   int          m_tcnt, m_lcnt;
   bit          s_vld [NSLOT];
   logic [63:0] s_adr [NSLOT];
   logic [17:0] s_sz  [NSLOT];
   logic [7:0]  s_own [NSLOT];
   bit          s_lng [NSLOT];

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   logic [31:0] live_addrs[$];

   int errors = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_cycles = 0;
   bit req_taken = 0;
   int watchdog = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp);
      $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
      errors++;
   endtask

   function automatic void model_init();
      m_low = m_base;
      m_high = m_base + TOTAL;
      m_tcnt = 0;
      m_lcnt = 0;
      for (int i = 0; i < NSLOT; i++) s_vld[i] = 0;
   endfunction

   function automatic logic [63:0] long_floor();
      if (LONG_BYTES >= TOTAL) return m_base;
      return m_base + TOTAL - LONG_BYTES;
   endfunction

   function automatic status_type model_alloc(input bit lng, input logic [63:0] cnt,
                                              input logic [63:0] aln,
                                              input logic [7:0] own,
                                              output logic [63:0] grant);
      logic [63:0] mask, start, lower, avail;
      int idx;
      grant = 0;
      idx = NSLOT;
      if (aln == 0) aln = 1;
      mask = aln - 1;
      if ((aln & mask) != 0) return ST_ALIGN_POW2;
      if (aln > MAX_ALIGN) return ST_ALIGN_BIG;
      if (m_tcnt + m_lcnt >= NSLOT) return ST_TABLE_FULL;
      if (cnt == 0) return ST_ZERO_SIZE;
      lower = m_low;
      if (lng && long_floor() > lower) lower = long_floor();
      avail = (m_high > lower) ? m_high - lower : 0;
      if (cnt > avail) return ST_NO_SPACE;
      if (!lng) begin
         start = m_low;
         if ((start & mask) != 0) begin
            start = (start + aln) & ~mask;
            if (start > m_high || m_high - start < cnt) return ST_NO_SPACE;
         end
      end else begin
         start = m_high - cnt;
         if ((start & mask) != 0) begin
            start &= ~mask;
            if (lower > start) return ST_NO_SPACE;
         end
      end
      if (start == 0) return ST_NO_SPACE;
      for (int i = 0; i < NSLOT; i++)
         if (!s_vld[i] && idx == NSLOT) idx = i;
      if (idx >= NSLOT) return ST_TABLE_FULL;
      s_vld[idx] = 1;
      s_adr[idx] = start;
      s_sz[idx] = cnt[17:0];
      s_own[idx] = own;
      s_lng[idx] = lng;
      if (lng) begin
         m_high = start;
         m_lcnt = (m_lcnt + 1) & 63;
      end else begin
         m_low = start + cnt;
         m_tcnt = (m_tcnt + 1) & 63;
      end
      grant = start;
      return ST_OK;
   endfunction

   function automatic status_type model_free(input bit lng, input logic [63:0] adr,
                                             input logic [7:0] own);
      int idx;
      logic [63:0] mark, e;
      idx = NSLOT;
      if (adr == 0) return ST_NULL_FREE;
      if (adr < m_base || adr >= m_base + TOTAL) return ST_OUTSIDE;
      for (int i = 0; i < NSLOT; i++)
         if (idx == NSLOT && s_vld[i] && s_adr[i] == adr) idx = i;
      if (idx >= NSLOT) return ST_NOT_ALLOC;
      if (s_own[idx] != own) return ST_OWNER;
      if (s_lng[idx] != lng) return ST_WRONG_KIND;
      s_vld[idx] = 0;
      if (!lng) begin
         if (m_tcnt > 0) m_tcnt--;
         mark = m_base;
         if (m_tcnt != 0)
            for (int i = 0; i < NSLOT; i++)
               if (s_vld[i] && !s_lng[i]) begin
                  e = s_adr[i] + 64'(s_sz[i]);
                  if (e > mark) mark = e;
               end
         m_low = mark;
      end else begin
         if (m_lcnt > 0) m_lcnt--;
         mark = m_base + TOTAL;
         if (m_lcnt != 0)
            for (int i = 0; i < NSLOT; i++)
               if (s_vld[i] && s_lng[i] && s_adr[i] < mark) mark = s_adr[i];
         m_high = mark;
      end
      return ST_OK;
   endfunction

   function automatic alloc_rsp_type predict_response(input alloc_req_type r);
      alloc_rsp_type x;
      logic [63:0] g;
      g = 0;
      case (r.op)
         OP_ALLOC_TEMP: x.st = model_alloc(1'b0, 64'(r.cnt), 64'(r.aln), r.own, g);
         OP_ALLOC_LONG: x.st = model_alloc(1'b1, 64'(r.cnt), 64'(r.aln), r.own, g);
         OP_FREE_TEMP:  x.st = model_free(1'b0, 64'(r.addr), r.own);
         default:       x.st = model_free(1'b1, 64'(r.addr), r.own);
      endcase
      x.grant = g[31:0];
      x.space = (m_high > m_low) ? 18'(m_high - m_low) : 18'd0;
      return x;
   endfunction

   // driver
   always @(negedge clock) begin
      alloc_req_type r;
      if (!reset) begin
         // req_taken holds the handshake seen at the last rising edge
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               expected_rsps.push_back(predict_response(r));
               req_valid <= 1;
               req_operation <= r.op;
               req_byte_count <= r.cnt;
               req_alignment <= r.aln;
               req_owner_tag <= r.own;
               req_free_address <= r.addr;
            end else
               req_valid <= 0;
         end
         rsp_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_idle_pct);
         if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      alloc_rsp_type x;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_status), 32'd0);
            end else begin
               x = expected_rsps.pop_front();
               if (rsp_status !== x.st)
                  report_mismatch("status", 32'(rsp_status), 32'(x.st));
               if (rsp_granted_address !== x.grant)
                  report_mismatch("granted_address", rsp_granted_address, x.grant);
               if (rsp_free_space !== x.space)
                  report_mismatch("free_space", 32'(rsp_free_space), 32'(x.space));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            watchdog <= 0;
         else
            watchdog <= watchdog + 1;
         if (watchdog >= WD_LIMIT) begin
            $display("two_ended_region_allocator_core verification failed");
            $finish;
         end
      end
   end

   task automatic add_req(input op_type op, input logic [17:0] cnt,
                          input logic [17:0] aln, input logic [7:0] own,
                          input logic [31:0] addr);
      alloc_req_type r;
      r.op = op; r.cnt = cnt; r.aln = aln; r.own = own; r.addr = addr;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_base(input logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_base_address <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      m_base = (v > 32'hFFFF_FFFF - TOTAL) ? 64'(32'hFFFF_FFFF - TOTAL) : 64'(v);
      model_init();
   endtask

   // Random transaction: half allocations with small sizes, half frees of live-ish
   // addresses, a share of noise over every field.
   task automatic add_random();
      int k;
      logic [17:0] cnt, aln;
      logic [7:0] own;
      logic [31:0] a;
      k = $urandom_range(99);
      own = 8'($urandom_range(3));
      if ($urandom_range(9) == 0) own = 8'($urandom);
      aln = 18'(1) << $urandom_range(13);
      if ($urandom_range(9) == 0) aln = 18'd0;
      else if ($urandom_range(19) == 0) aln = 18'($urandom);
      else if ($urandom_range(29) == 0) aln = 18'(1) << $urandom_range(17);
      cnt = 18'($urandom_range(1, 4096));
      if ($urandom_range(19) == 0) cnt = 18'($urandom);
      else if ($urandom_range(29) == 0) cnt = 18'd0;
      if (k < 50) add_req(k < 30 ? OP_ALLOC_TEMP : OP_ALLOC_LONG, cnt, aln, own, $urandom);
      else begin
         if (live_addrs.size() > 0 && $urandom_range(4) != 0) begin
            a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            if ($urandom_range(7) == 0) own = 8'($urandom);
         end else if ($urandom_range(1))
            a = 32'(m_base) + $urandom_range(TOTAL - 1);
         else
            a = $urandom;
         if ($urandom_range(29) == 0) a = 32'd0;
         add_req(k < 75 ? OP_FREE_TEMP : OP_FREE_LONG, cnt, aln, own, a);
      end
   endtask

   // Learn granted addresses so frees can hit them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_OK &&
          rsp_granted_address != 0) begin
         live_addrs.push_back(rsp_granted_address);
         if (live_addrs.size() > 64) void'(live_addrs.pop_front());
      end
   end

   initial begin
      int n;
      m_base = 64'(BASE_RESET);
      model_init();
      send_idle_pct = 38; recv_idle_pct = 81;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part, sender 38 / receiver 81
      add_req(OP_ALLOC_TEMP, 18'd100, 18'd3, 8'd1, 32'd0);
      add_req(OP_ALLOC_TEMP, 18'd100, 18'h3FFFF, 8'd1, 32'd0);
      add_req(OP_ALLOC_TEMP, 18'd100, 18'd0, 8'd1, 32'd0);
      add_req(OP_ALLOC_TEMP, 18'd0, 18'd1, 8'd1, 32'd0);
      add_req(OP_ALLOC_LONG, 18'd16, 18'd131072, 8'd2, 32'd0);
      add_req(OP_ALLOC_LONG, 18'd100, 18'd64, 8'hFF, 32'd0);
      add_req(OP_ALLOC_TEMP, 18'h3FFFF, 18'd1, 8'd1, 32'd0);
      add_req(OP_ALLOC_TEMP, 18'd5, 18'd131072, 8'd1, 32'd0);
      add_req(OP_ALLOC_LONG, 18'd9000, 18'd1, 8'd1, 32'd0);
      add_req(OP_FREE_TEMP, 18'd0, 18'd0, 8'd1, 32'd0);
      add_req(OP_FREE_TEMP, 18'd0, 18'd0, 8'd1, 32'hFFFF_FFFF);
      add_req(OP_FREE_TEMP, 18'd0, 18'd0, 8'd1, BASE_RESET + 32'd7);
      add_req(OP_FREE_TEMP, 18'd0, 18'd0, 8'd9, BASE_RESET);
      add_req(OP_FREE_LONG, 18'd0, 18'd0, 8'd1, BASE_RESET);
      add_req(OP_FREE_TEMP, 18'd0, 18'd0, 8'd1, BASE_RESET);
      add_req(OP_FREE_LONG, 18'd0, 18'd0, 8'hFF, BASE_RESET + TOTAL - 128);
      for (int i = 0; i < 34; i++) add_req(OP_ALLOC_TEMP, 18'd8, 18'd1, 8'd0, 32'd0);
      drain();

      // phase 1: extremes of base, sender 38 / receiver 81
      write_base(32'hFFFF_FFFF);
      for (int i = 0; i < 150; i++) add_random();
      add_req(OP_ALLOC_LONG, 18'd100, 18'd1, 8'd0, 32'd0);
      drain();
      write_base(32'h0);
      for (int i = 0; i < 400; i++) add_random();
      drain();

      // phase 2: roles swapped, plus a long receiver hold-off
      write_base(32'h0002_0000);
      send_idle_pct = 81; recv_idle_pct = 38;
      hold_cycles = 300;
      for (int i = 0; i < 20; i++) add_random();
      wait (hold_cycles == 0);
      for (int i = 0; i < 400; i++) add_random();
      drain();

      // phase 3: no idling, back to the reset base
      write_base(BASE_RESET);
      send_idle_pct = 0; recv_idle_pct = 0;
      n = 0;
      while (n < 650) begin
         add_random();
         n++;
      end
      drain();

      if (errors == 0)
         $display("two_ended_region_allocator_core verification clean");
      else
         $display("two_ended_region_allocator_core verification failed");
      $finish;
   end

endmodule
